@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the console writer RTL
// All checks sample on i_clk and are held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the same cycle as its trigger
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after its trigger
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_STAR = 8'h2A;

    // Attributes
    localparam logic [7:0] PUT_ATTR   = 8'h0F;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam int TAB_STEP = 8;
    localparam int OFFSET_W = 11;
    localparam int Q_DEPTH  = 2;

    // Decoded operation handed from front end to back end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_CR,
        OP_TAB,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [7:0] row;
        logic [7:0] col;
    } t_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [7:0]          read_char;
        logic [7:0]          read_attr;
    } t_result;

endpackage

`default_nettype wire

@@ sv/tcw_fifo.sv @@
// ----------------------------------------------------------------------------
// tcw_fifo
// Small register queue with full/empty flags, used between pipeline parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]  LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CNW-1:0] FULL_CNT = CNW'(DEPTH);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CNW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transactions, classifies them into operations and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_cmd,
    input  logic [7:0]    i_char_code,
    input  logic [7:0]    i_row,
    input  logic [7:0]    i_col,
    input  logic          i_pop,
    output logic          o_empty,
    output tcw_pkg::t_item o_item
);

    import tcw_pkg::*;

    logic       in_range;
    logic [7:0] ch_map;
    t_item      item;
    logic       q_full;

    // Cell range check and NUL substitution
    assign in_range = (i_row < 8'(ROWS)) && (i_col < 8'(COLS));
    assign ch_map   = (i_char_code == CH_NUL) ? CH_STAR : i_char_code;

    // Classify the command
    always_comb begin
        item.ch  = ch_map;
        item.row = i_row;
        item.col = i_col;
        case (i_cmd)
            CMD_PUT: begin
                case (ch_map)
                    CH_LF:   item.op = OP_NEWLINE;
                    CH_CR:   item.op = OP_CR;
                    CH_TAB:  item.op = OP_TAB;
                    default: item.op = OP_PUT;
                endcase
            end
            CMD_WRITE: begin
                item.ch = i_char_code;
                item.op = in_range ? OP_WRITE : OP_NOP;
            end
            CMD_READ: item.op = in_range ? OP_READ : OP_NOP;
            default:  item.op = OP_NOP;
        endcase
    end

    // Hold off intake while the back end clears the screen
    assign o_full = q_full || i_hold;

    tcw_fifo #(
        .W     ($bits(t_item)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !i_hold),
        .i_data  (item),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

@@ sv/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued operations on the screen memory and cursor; scrolls by
// moving a top-row pointer and clearing one row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcw_back #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  tcw_pkg::t_item   i_q_item,
    input  logic             i_r_full,
    output logic             o_r_push,
    output tcw_pkg::t_result o_r_res,
    output logic             o_init_busy
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = $clog2(CELLS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [7:0]    r_attr;
    logic [RW-1:0] r_crow;
    logic [CW-1:0] r_ccol;
    logic [RW-1:0] r_top;
    logic [RW-1:0] r_prow;
    logic [AW-1:0] r_caddr;
    logic [CW-1:0] r_cnt;
    t_item         r_item;
    logic [15:0]   r_screen [CELLS];
    logic [15:0]   r_rdata;

    logic [RW-1:0] row_sel;
    logic [RW:0]   prow_sum;
    logic [RW-1:0] prow;
    logic [CW-1:0] col_sel;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] base_addr;
    logic [RW:0]   row_x;
    logic [CW:0]   col_x;
    logic          scroll;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] cur_off;

    // Physical row of the target cell: logical row rotated by the top pointer
    always_comb begin
        if (i_q_item.op inside {OP_PUT, OP_NEWLINE, OP_CR, OP_TAB}) begin
            row_sel = r_crow;
        end else begin
            row_sel = i_q_item.row[RW-1:0];
        end
        prow_sum = {1'b0, r_top} + {1'b0, row_sel};
        if (prow_sum >= (RW+1)'(ROWS)) begin
            prow = RW'(prow_sum - (RW+1)'(ROWS));
        end else begin
            prow = prow_sum[RW-1:0];
        end
    end

    // Cell address and base of the row freed by a scroll
    assign col_sel   = (r_item.op == OP_PUT) ? r_ccol : r_item.col[CW-1:0];
    assign cell_addr = AW'(r_prow) * AW'(COLS) + AW'(col_sel);
    assign base_addr = AW'(r_top) * AW'(COLS);

    // Cursor movement, column wrap and scroll detect
    always_comb begin
        row_x = {1'b0, r_crow};
        col_x = {1'b0, r_ccol};
        case (r_item.op)
            OP_NEWLINE: row_x = row_x + 1'b1;
            OP_CR:      col_x = '0;
            OP_TAB:     col_x = col_x + (CW+1)'(TAB_STEP);
            OP_PUT:     col_x = col_x + 1'b1;
            OP_WRITE: begin
                row_x = {1'b0, r_item.row[RW-1:0]};
                col_x = {1'b0, r_item.col[CW-1:0]};
            end
            default: ;
        endcase
        if (col_x >= (CW+1)'(COLS)) begin
            col_x = '0;
            row_x = row_x + 1'b1;
        end
        scroll = (row_x >= (RW+1)'(ROWS));
    end

    // Screen memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = cell_addr;
        mem_wdata = {r_item.ch, r_attr};
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_addr  = r_caddr;
                mem_wdata = '0;
            end
            S_EXEC: begin
                mem_we = (r_item.op == OP_PUT) || (r_item.op == OP_WRITE);
                if (r_item.op == OP_PUT) begin
                    mem_wdata = {r_item.ch, PUT_ATTR};
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_caddr;
                mem_wdata = {8'h00, r_attr};
            end
            default: ;
        endcase
    end

    // Screen memory: character in the upper byte, attribute in the lower
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_screen[mem_addr];
    end

    // Handshakes and result
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty && !i_r_full;
    assign o_r_push    = (r_state == S_DONE);
    assign o_init_busy = (r_state == S_INIT);
    assign cur_off     = AW'(r_crow) * AW'(COLS) + AW'(r_ccol);

    always_comb begin
        o_r_res.cursor_offset = OFFSET_W'(cur_off);
        if (r_item.op == OP_READ) begin
            o_r_res.read_char = r_rdata[15:8];
            o_r_res.read_attr = r_rdata[7:0];
        end else begin
            o_r_res.read_char = '0;
            o_r_res.read_attr = '0;
        end
    end

    // Sequencer, cursor and attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_attr  <= RESET_ATTR;
            r_crow  <= '0;
            r_ccol  <= '0;
            r_top   <= '0;
            r_caddr <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            case (r_state)
                S_INIT: begin
                    if (r_caddr == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_caddr <= r_caddr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_item  <= i_q_item;
                        r_prow  <= prow;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (scroll) begin
                        r_crow  <= LAST_ROW;
                        r_ccol  <= '0;
                        r_top   <= (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                        r_caddr <= base_addr;
                        r_cnt   <= '0;
                        r_state <= S_CLEAR;
                    end else begin
                        r_crow  <= row_x[RW-1:0];
                        r_ccol  <= col_x[CW-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_CLEAR: begin
                    if (r_cnt == LAST_COL) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_caddr <= r_caddr + 1'b1;
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_INIT;
            endcase
        end
    end

    // Checks
    `TCW_ASSERT_ALWAYS(a_cursor_row, r_crow <= LAST_ROW, "cursor row out of range")
    `TCW_ASSERT_ALWAYS(a_cursor_col, r_ccol <= LAST_COL, "cursor column out of range")
    `TCW_ASSERT_SAME(a_push_room, o_r_push, !i_r_full, "result pushed into full queue")
    `TCW_ASSERT_NEXT(a_scroll_home, (r_state == S_EXEC) && scroll,
        (r_crow == LAST_ROW) && (r_ccol == '0) && (r_state == S_CLEAR),
        "scroll did not home the cursor")

endmodule

`default_nettype wire

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Character/attribute text screen with cursor, control codes and scrolling.
//
//   Channel   Handshake        Payload
//   -------   --------------   ------------------------------------------
//   input     push / full      i_cmd, i_char_code, i_row, i_col
//   result    empty / pop      o_cursor_offset, o_read_char, o_read_attr
//   config    i_cfg_we         i_cfg_wdata (text attribute)
//
// In the back end each transaction passes through a queue pop, one access to
// the single-port screen memory and a result push. A scroll also clears the
// freed row (the screen is a ring of rows under a top pointer). After reset
// a clearing pass over every cell of the screen runs with full held high.
// Two-entry queues sit on both sides of the back end, so intake continues
// while results wait to be popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] o_cursor_offset,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    import tcw_pkg::*;

    t_item   q_item;
    logic    q_empty;
    logic    q_pop;
    logic    init_busy;
    t_result res_in;
    t_result res_out;
    logic    res_push;
    logic    res_full;

    // Front end: intake and classification
    tcw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (init_busy),
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_item      (q_item)
    );

    // Back end: screen memory and cursor
    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_item    (q_item),
        .i_r_full    (res_full),
        .o_r_push    (res_push),
        .o_r_res     (res_in),
        .o_init_busy (init_busy)
    );

    // Result queue
    tcw_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_cursor_offset = res_out.cursor_offset;
    assign o_read_char     = res_out.read_char;
    assign o_read_attr     = res_out.read_attr;

endmodule

`default_nettype wire
